FILE: src/acor_pkg.sv
`timescale 1ns / 1ps

package acor_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam int IP_W = 32;
   localparam int MAC_W = 48;
   localparam int STAMP_W = 32;
   localparam int TSIZE_W = 9;
   localparam int ENTRY_W = IP_W + MAC_W + STAMP_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TABLE_SIZE = 3'd0;

   localparam logic [TSIZE_W-1:0] TSIZE_RESET = 9'd256;
   localparam logic [STAMP_W-1:0] STAMP_LAST = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_MISS    = 2'd1,
      ST_REFUSED = 2'd2
   } status_type;

   typedef struct packed {
      status_type        status;
      logic [MAC_W-1:0]  mac_out;
      logic [STAMP_W-1:0] stamp_out;
      logic              evicted;
      logic [IP_W-1:0]   evicted_ip;
   } result_type;

   typedef struct packed {
      logic             clear;
      logic             take;
      logic             oldest;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   idx;
      logic [IP_W-1:0]    ip;
      logic [MAC_W-1:0]   mac;
      logic [STAMP_W-1:0] stamp;
   } scan_stat_type;

   function automatic logic [CNT_W-1:0] limit_size(input logic [TSIZE_W-1:0] ts);
      logic [CNT_W-1:0] lim;
      if (ts == '0) begin
         lim = CNT_W'(1);
      end else if (int'(ts) > CAPACITY) begin
         lim = CNT_W'(CAPACITY);
      end else begin
         lim = CNT_W'(ts);
      end
      return lim;
   endfunction

endpackage

FILE: src/acor_req_if.sv
`timescale 1ns / 1ps

interface acor_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 opcode;
   logic [acor_pkg::IP_W-1:0]  ip_addr;
   logic [acor_pkg::MAC_W-1:0] mac_addr;

   modport source (output valid, output opcode, output ip_addr, output mac_addr,
                   input ready);
   modport sink (input valid, input opcode, input ip_addr, input mac_addr,
                 output ready);
endinterface

FILE: src/acor_rsp_if.sv
`timescale 1ns / 1ps

interface acor_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [acor_pkg::MAC_W-1:0]   mac_out;
   logic [acor_pkg::STAMP_W-1:0] stamp_out;
   logic                         evicted;
   logic [acor_pkg::IP_W-1:0]    evicted_ip;

   modport source (output valid, output status, output mac_out, output stamp_out,
                   output evicted, output evicted_ip, input ready);
   modport sink (input valid, input status, input mac_out, input stamp_out,
                 input evicted, input evicted_ip, output ready);
endinterface

FILE: src/acor_ram.sv
`timescale 1ns / 1ps

module acor_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/acor_scan.sv
`timescale 1ns / 1ps

module acor_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  acor_pkg::scan_ctl_type          ctl,
   input  logic [acor_pkg::IP_W-1:0]       key_ip,
   input  logic [acor_pkg::ENTRY_W-1:0]    entry,
   output acor_pkg::scan_stat_type         stat
);

   logic [acor_pkg::IP_W-1:0]    e_ip;
   logic [acor_pkg::MAC_W-1:0]   e_mac;
   logic [acor_pkg::STAMP_W-1:0] e_stamp;
   logic [acor_pkg::STAMP_W-1:0] cmp_a;
   logic [acor_pkg::STAMP_W-1:0] cmp_b;
   logic                         less;
   logic                         hit;
   logic                         take;

   logic                         found_ff, found_in;
   logic [acor_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [acor_pkg::IP_W-1:0]    ip_ff, ip_in;
   logic [acor_pkg::MAC_W-1:0]   mac_ff, mac_in;
   logic [acor_pkg::STAMP_W-1:0] stamp_ff, stamp_in;

   assign e_ip    = entry[acor_pkg::ENTRY_W-1 -: acor_pkg::IP_W];
   assign e_mac   = entry[acor_pkg::STAMP_W +: acor_pkg::MAC_W];
   assign e_stamp = entry[acor_pkg::STAMP_W-1:0];

   // one comparator: oldest wants entry < best, lookup wants best < entry
   assign cmp_a = ctl.oldest ? e_stamp : stamp_ff;
   assign cmp_b = ctl.oldest ? stamp_ff : e_stamp;
   assign less  = cmp_a < cmp_b;
   assign hit   = ctl.oldest || (e_ip == key_ip);
   assign take  = ctl.take && hit && (!found_ff || less);

   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      ip_in    = ip_ff;
      mac_in   = mac_ff;
      stamp_in = stamp_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         idx_in   = ctl.idx;
         ip_in    = e_ip;
         mac_in   = e_mac;
         stamp_in = e_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff   <= idx_in;
      ip_ff    <= ip_in;
      mac_ff   <= mac_in;
      stamp_ff <= stamp_in;
   end

   assign stat.found = found_ff;
   assign stat.idx   = idx_ff;
   assign stat.ip    = ip_ff;
   assign stat.mac   = mac_ff;
   assign stat.stamp = stamp_ff;

endmodule

FILE: src/address_cache_oldest_replace.sv
// Address cache with oldest-first replacement: each request is a lookup, an insert, a
// clear or a no-op, and yields exactly one response. The entries live in one RAM with a
// single registered read port; the filled slots are always slots 0 up to the fill count,
// so no clearing pass is needed after reset and clear takes effect at once. A lookup, or
// an insert into a full table, reads the filled slots one per cycle through one shared
// stamp comparator, then passes through the drain and resolve states; such an insert
// then writes its slot. An insert into a free slot goes straight to the write state; a
// clear, a refused insert, a no-op and a lookup of an empty table go straight to the
// finish state. One request is processed at a time; a finished response waits in an
// output register while the next request is accepted. table_size is written through the
// APB port at byte address 0 and is read back there.
`timescale 1ns / 1ps

module address_cache_oldest_replace (
   input  logic                                clock,
   input  logic                                reset,
   acor_req_if.sink                            req_ch,
   acor_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [acor_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [acor_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [acor_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_RESOLVE,
      S_WRITE,
      S_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   acor_pkg::op_type             op_ff, op_in;
   logic [acor_pkg::IP_W-1:0]    ip_ff, ip_in;
   logic [acor_pkg::MAC_W-1:0]   mac_ff, mac_in;
   logic [acor_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [acor_pkg::IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [acor_pkg::IDX_W-1:0]   slot_ff, slot_in;
   logic [acor_pkg::CNT_W-1:0]   used_ff, used_in;
   logic [acor_pkg::STAMP_W-1:0] stamp_ff, stamp_in;
   logic [acor_pkg::TSIZE_W-1:0] tsize_ff, tsize_in;
   acor_pkg::result_type         res_ff, res_in;
   acor_pkg::result_type         rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   acor_pkg::op_type             req_op;
   logic                         csr_write;
   logic                         ram_we;
   logic [acor_pkg::IDX_W-1:0]   ram_waddr;
   logic [acor_pkg::ENTRY_W-1:0] ram_wdata;
   logic [acor_pkg::IDX_W-1:0]   ram_raddr;
   logic [acor_pkg::ENTRY_W-1:0] ram_rdata;
   acor_pkg::scan_ctl_type       scan_ctl;
   acor_pkg::scan_stat_type      scan_stat;

   acor_ram #(
      .WIDTH (acor_pkg::ENTRY_W),
      .DEPTH (acor_pkg::CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   acor_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctl    (scan_ctl),
      .key_ip (ip_ff),
      .entry  (ram_rdata),
      .stat   (scan_stat)
   );

   assign req_op    = acor_pkg::op_type'(req_ch.opcode);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr == acor_pkg::ADDR_TABLE_SIZE)
                      ? acor_pkg::CSR_DATA_W'(tsize_ff) : '0;

   assign req_ch.ready = (state_ff == S_IDLE);

   assign ram_waddr = slot_ff;
   assign ram_wdata = {ip_ff, mac_ff, stamp_ff};
   assign ram_raddr = idx_ff[acor_pkg::IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ip_in        = ip_ff;
      mac_in       = mac_ff;
      idx_in       = idx_ff;
      rd_pend_in   = 1'b0;
      pend_idx_in  = pend_idx_ff;
      slot_in      = slot_ff;
      used_in      = used_ff;
      stamp_in     = stamp_ff;
      tsize_in     = tsize_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;

      scan_ctl.clear  = 1'b0;
      scan_ctl.take   = rd_pend_ff;
      scan_ctl.oldest = (op_ff == acor_pkg::OP_INSERT);
      scan_ctl.idx    = pend_idx_ff;

      if (csr_write && paddr == acor_pkg::ADDR_TABLE_SIZE) begin
         tsize_in = pwdata[acor_pkg::TSIZE_W-1:0];
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in          = req_op;
               ip_in          = req_ch.ip_addr;
               mac_in         = req_ch.mac_addr;
               idx_in         = '0;
               res_in         = '0;
               res_in.status  = acor_pkg::ST_DONE;
               scan_ctl.clear = 1'b1;
               case (req_op)
                  acor_pkg::OP_LOOKUP: begin
                     if (used_ff == '0) begin
                        res_in.status = acor_pkg::ST_MISS;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  acor_pkg::OP_INSERT: begin
                     if (stamp_ff == acor_pkg::STAMP_LAST) begin
                        res_in.status = acor_pkg::ST_REFUSED;
                        state_in      = S_FINISH;
                     end else if (used_ff < acor_pkg::limit_size(tsize_ff)) begin
                        slot_in  = used_ff[acor_pkg::IDX_W-1:0];
                        used_in  = used_ff + acor_pkg::CNT_W'(1);
                        state_in = S_WRITE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  acor_pkg::OP_CLEAR: begin
                     used_in  = '0;
                     state_in = S_FINISH;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_pend_in  = 1'b1;
            pend_idx_in = idx_ff[acor_pkg::IDX_W-1:0];
            idx_in      = idx_ff + acor_pkg::CNT_W'(1);
            if (idx_ff + acor_pkg::CNT_W'(1) == used_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            if (op_ff == acor_pkg::OP_INSERT) begin
               slot_in           = scan_stat.idx;
               res_in.evicted    = 1'b1;
               res_in.evicted_ip = scan_stat.ip;
               state_in          = S_WRITE;
            end else if (scan_stat.found) begin
               res_in.mac_out   = scan_stat.mac;
               res_in.stamp_out = scan_stat.stamp;
               state_in         = S_FINISH;
            end else begin
               res_in.status = acor_pkg::ST_MISS;
               state_in      = S_FINISH;
            end
         end
         S_WRITE: begin
            ram_we           = 1'b1;
            res_in.stamp_out = stamp_ff;
            stamp_in         = stamp_ff + acor_pkg::STAMP_W'(1);
            state_in         = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_pend_ff   <= 1'b0;
         used_ff      <= '0;
         stamp_ff     <= '0;
         tsize_ff     <= acor_pkg::TSIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         used_ff      <= used_in;
         stamp_ff     <= stamp_in;
         tsize_ff     <= tsize_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ip_ff       <= ip_in;
      mac_ff      <= mac_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_ff.status;
   assign rsp_ch.mac_out    = rsp_ff.mac_out;
   assign rsp_ch.stamp_out  = rsp_ff.stamp_out;
   assign rsp_ch.evicted    = rsp_ff.evicted;
   assign rsp_ch.evicted_ip = rsp_ff.evicted_ip;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      int'(used_ff) <= acor_pkg::CAPACITY)
      else $error("fill count above capacity");

   a_stamp_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |=> stamp_ff == $past(stamp_ff) + acor_pkg::STAMP_W'(1))
      else $error("stamp counter did not advance after a write");

   a_victim_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESOLVE && op_ff == acor_pkg::OP_INSERT) |-> scan_stat.found)
      else $error("replacement scan found no victim");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> idx_ff < used_ff)
      else $error("scan read beyond the filled slots");
`endif

endmodule

FILE: tb/address_cache_oldest_replace_tb.sv
`timescale 1ns / 1ps

module address_cache_oldest_replace_tb;
   import acor_pkg::*;

   localparam int CYCLE_LIMIT = 1_200_000;
   localparam int NUM_PHASES = 7;

   typedef struct {
      bit                 is_cfg;
      logic [TSIZE_W-1:0] tsize;
      op_type             op;
      logic [IP_W-1:0]    ip;
      logic [MAC_W-1:0]   mac;
      bit                 typed;
      result_type         want;
   } script_row;

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   acor_req_if req_if ();
   acor_rsp_if rsp_if ();

   address_cache_oldest_replace dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // cache image
   logic [IP_W-1:0]    cache_ip    [CAPACITY];
   logic [MAC_W-1:0]   cache_mac   [CAPACITY];
   logic [STAMP_W-1:0] cache_stamp [CAPACITY];
   bit                 cache_valid [CAPACITY];
   int                 fill_count = 0;
   logic [STAMP_W-1:0] stamp_next = '0;
   logic [TSIZE_W-1:0] size_reg = TSIZE_RESET;

   result_type       rsp_due [$];
   script_row        script [$];
   logic [IP_W-1:0]  ip_pool [$];
   int               mismatches = 0;
   int               cycles = 0;
   bit               steady = 1'b0;
   int               phase_size [NUM_PHASES];
   int               phase_len [NUM_PHASES];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic result_type resolve_request(input op_type op, input logic [IP_W-1:0] ip,
                                                  input logic [MAC_W-1:0] mac);
      result_type r;
      int hit;
      int slot;
      int cap_now;
      r = '0;
      case (op)
         OP_LOOKUP: begin
            hit = -1;
            for (int i = 0; i < CAPACITY; i++) begin
               if (cache_valid[i] && cache_ip[i] == ip) begin
                  if (hit < 0 || cache_stamp[i] > cache_stamp[hit]) hit = i;
               end
            end
            if (hit < 0) begin
               r.status = ST_MISS;
            end else begin
               r.status = ST_DONE;
               r.mac_out = cache_mac[hit];
               r.stamp_out = cache_stamp[hit];
            end
         end
         OP_INSERT: begin
            if (stamp_next == STAMP_LAST) begin
               r.status = ST_REFUSED;
            end else begin
               if (size_reg == '0) cap_now = 1;
               else if (int'(size_reg) > CAPACITY) cap_now = CAPACITY;
               else cap_now = int'(size_reg);
               slot = -1;
               if (fill_count < cap_now) begin
                  slot = fill_count;
                  fill_count++;
               end else begin
                  // oldest valid entry, lowest index on a tie
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (cache_valid[i] && (slot < 0 || cache_stamp[i] < cache_stamp[slot]))
                        slot = i;
                  end
                  if (slot >= 0) begin
                     r.evicted = 1'b1;
                     r.evicted_ip = cache_ip[slot];
                  end else begin
                     slot = 0;
                  end
               end
               cache_ip[slot] = ip;
               cache_mac[slot] = mac;
               cache_stamp[slot] = stamp_next;
               cache_valid[slot] = 1'b1;
               r.status = ST_DONE;
               r.stamp_out = stamp_next;
               stamp_next++;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < CAPACITY; i++) cache_valid[i] = 1'b0;
            fill_count = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic result_type mk_rsp(input status_type st, input logic [MAC_W-1:0] mac,
                                         input logic [STAMP_W-1:0] stamp, input logic ev,
                                         input logic [IP_W-1:0] ev_ip);
      result_type r;
      r.status = st;
      r.mac_out = mac;
      r.stamp_out = stamp;
      r.evicted = ev;
      r.evicted_ip = ev_ip;
      return r;
   endfunction

   function automatic void add_item(input op_type op, input logic [IP_W-1:0] ip,
                                    input logic [MAC_W-1:0] mac);
      script_row row;
      row = '{is_cfg: 1'b0, tsize: '0, op: op, ip: ip, mac: mac, typed: 1'b0, want: '0};
      script.push_back(row);
   endfunction

   function automatic void add_check(input op_type op, input logic [IP_W-1:0] ip,
                                     input logic [MAC_W-1:0] mac, input result_type want);
      script_row row;
      row = '{is_cfg: 1'b0, tsize: '0, op: op, ip: ip, mac: mac, typed: 1'b1, want: want};
      script.push_back(row);
   endfunction

   function automatic void add_size(input logic [TSIZE_W-1:0] value);
      script_row row;
      row = '{is_cfg: 1'b1, tsize: value, op: OP_NOP, ip: '0, mac: '0, typed: 1'b0, want: '0};
      script.push_back(row);
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
   endtask

   task automatic issue_req(input op_type op, input logic [IP_W-1:0] ip,
                            input logic [MAC_W-1:0] mac, input bit typed,
                            input result_type want);
      result_type pred;
      while (!steady && $urandom_range(0, 99) < 28) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.opcode = op;
      req_if.ip_addr = ip;
      req_if.mac_addr = mac;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pred = resolve_request(op, ip, mac);
      rsp_due.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   task automatic drain_requests();
      req_if.valid = 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_size(input logic [TSIZE_W-1:0] value);
      logic [CSR_DATA_W-1:0] back;
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = ADDR_TABLE_SIZE;
      pwdata = CSR_DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      size_reg = value;
      @(negedge clock);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      back = prdata;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      if (back !== CSR_DATA_W'(value)) note_mismatch("table_size readback", 64'(value), 64'(back));
   endtask

   task automatic random_req(input bit fill_phase);
      int pick;
      int span;
      op_type op;
      logic [IP_W-1:0] ip;
      logic [MAC_W-1:0] mac;
      pick = $urandom_range(0, 99);
      if (fill_phase) begin
         if (pick < 80) op = OP_INSERT;
         else if (pick < 98) op = OP_LOOKUP;
         else op = OP_NOP;
      end else begin
         if (pick < 45) op = OP_INSERT;
         else if (pick < 88) op = OP_LOOKUP;
         else if (pick < 95) op = OP_CLEAR;
         else op = OP_NOP;
      end
      ip = $urandom;
      mac = {16'($urandom), $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         ip = '0;
         mac = '0;
      end else if (pick < 8) begin
         ip = '1;
         mac = '1;
      end else if (ip_pool.size() != 0 &&
                   ((op == OP_LOOKUP && pick < 72) || (op == OP_INSERT && pick < 22))) begin
         // favor recent addresses so lookups hit
         span = (ip_pool.size() < 6 || pick < 30) ? ip_pool.size() : 6;
         ip = ip_pool[ip_pool.size() - 1 - $urandom_range(0, span - 1)];
      end
      if (op == OP_INSERT) begin
         ip_pool.push_back(ip);
         if (ip_pool.size() > 48) void'(ip_pool.pop_front());
      end
      issue_req(op, ip, mac, 1'b0, '0);
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(0, 99) >= 28);
   end

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (rsp_due.size() == 0) begin
            note_mismatch("response with nothing pending", '0, 64'(rsp_if.stamp_out));
         end else begin
            want = rsp_due.pop_front();
            if (rsp_if.status !== want.status)
               note_mismatch("status", 64'(want.status), 64'(rsp_if.status));
            if (rsp_if.mac_out !== want.mac_out)
               note_mismatch("mac_out", 64'(want.mac_out), 64'(rsp_if.mac_out));
            if (rsp_if.stamp_out !== want.stamp_out)
               note_mismatch("stamp_out", 64'(want.stamp_out), 64'(rsp_if.stamp_out));
            if (rsp_if.evicted !== want.evicted)
               note_mismatch("evicted", 64'(want.evicted), 64'(rsp_if.evicted));
            if (rsp_if.evicted_ip !== want.evicted_ip)
               note_mismatch("evicted_ip", 64'(want.evicted_ip), 64'(rsp_if.evicted_ip));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("address_cache_oldest_replace_tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.opcode = OP_LOOKUP;
      req_if.ip_addr = '0;
      req_if.mac_addr = '0;
      rsp_if.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      phase_size = '{4, 0, 256, 37, 2, 511, 1};
      phase_len = '{50, 30, 340, 50, 30, 30, 20};

      add_check(OP_LOOKUP, 32'h0000_0000, '0, mk_rsp(ST_MISS, '0, '0, 1'b0, '0));
      add_check(OP_LOOKUP, 32'hFFFF_FFFF, '0, mk_rsp(ST_MISS, '0, '0, 1'b0, '0));
      add_check(OP_INSERT, 32'h0000_0000, 48'h0, mk_rsp(ST_DONE, '0, 32'd0, 1'b0, '0));
      add_check(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                mk_rsp(ST_DONE, '0, 32'd1, 1'b0, '0));
      add_check(OP_LOOKUP, 32'hFFFF_FFFF, '0,
                mk_rsp(ST_DONE, 48'hFFFF_FFFF_FFFF, 32'd1, 1'b0, '0));
      add_check(OP_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF,
                mk_rsp(ST_DONE, 48'h0, 32'd0, 1'b0, '0));
      add_check(OP_INSERT, 32'h0000_0000, 48'h0123_4567_89AB,
                mk_rsp(ST_DONE, '0, 32'd2, 1'b0, '0));
      add_check(OP_LOOKUP, 32'h0000_0000, '0,
                mk_rsp(ST_DONE, 48'h0123_4567_89AB, 32'd2, 1'b0, '0));
      add_check(OP_NOP, 32'hDEAD_BEEF, 48'hA5A5_5A5A_F00F, mk_rsp(ST_DONE, '0, '0, 1'b0, '0));
      add_check(OP_CLEAR, 32'h1234_5678, 48'h1, mk_rsp(ST_DONE, '0, '0, 1'b0, '0));
      add_check(OP_LOOKUP, 32'h0000_0000, '0, mk_rsp(ST_MISS, '0, '0, 1'b0, '0));
      add_check(OP_INSERT, 32'hC0A8_0001, 48'h00AA_BBCC_DDEE,
                mk_rsp(ST_DONE, '0, 32'd3, 1'b0, '0));
      add_size(9'd0);
      add_check(OP_INSERT, 32'h0A00_0001, 48'h11, mk_rsp(ST_DONE, '0, 32'd4, 1'b1, 32'hC0A8_0001));
      add_check(OP_INSERT, 32'h0A00_0002, 48'h22, mk_rsp(ST_DONE, '0, 32'd5, 1'b1, 32'h0A00_0001));
      add_size(9'd3);
      add_check(OP_INSERT, 32'h0A00_0003, 48'h33, mk_rsp(ST_DONE, '0, 32'd6, 1'b0, '0));
      add_check(OP_INSERT, 32'h0A00_0004, 48'h44, mk_rsp(ST_DONE, '0, 32'd7, 1'b0, '0));
      add_check(OP_INSERT, 32'h0A00_0005, 48'h55, mk_rsp(ST_DONE, '0, 32'd8, 1'b1, 32'h0A00_0002));
      add_size(9'd1);
      add_check(OP_INSERT, 32'h0A00_0006, 48'h66, mk_rsp(ST_DONE, '0, 32'd9, 1'b1, 32'h0A00_0003));
      add_size(9'd511);
      add_check(OP_INSERT, 32'h0A00_0007, 48'h77, mk_rsp(ST_DONE, '0, 32'd10, 1'b0, '0));
      add_check(OP_LOOKUP, 32'h0A00_0003, '0, mk_rsp(ST_MISS, '0, '0, 1'b0, '0));
      add_item(OP_LOOKUP, 32'h0A00_0006, '0);
      add_item(OP_LOOKUP, 32'h0A00_0005, '0);

      repeat (6) @(negedge clock);
      reset = 1'b0;

      foreach (script[k]) begin
         if (script[k].is_cfg) begin
            drain_requests();
            write_size(script[k].tsize);
         end else begin
            issue_req(script[k].op, script[k].ip, script[k].mac, script[k].typed, script[k].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_requests();
         write_size(TSIZE_W'(phase_size[p]));
         for (int k = 0; k < phase_len[p]; k++) begin
            steady = (p == 2 && k < 120);
            // hold off until the table has answered everything
            if (p == 2 && k == 25) drain_requests();
            random_req(p == 2);
         end
         steady = 1'b0;
      end

      drain_requests();
      repeat (300) @(negedge clock);
      if (mismatches == 0 && rsp_due.size() == 0) begin
         $display("address_cache_oldest_replace_tb: done, clean");
      end else begin
         $display("address_cache_oldest_replace_tb: done, errors");
      end
      $finish;
   end

endmodule
